/* hdl/tccw_pkg.sv */
// shared types, constants and codes of the text console character writer
package tccw_pkg;

    localparam int COLUMNS_DEF   = 80;
    localparam int ROWS_DEF      = 25;
    localparam int TAB_WIDTH_DEF = 4;

    localparam int OPW = 2;
    localparam int CHW = 8;
    localparam int RW  = 5;
    localparam int CW  = 7;
    localparam int ATW = 8;
    localparam int XW  = 7;
    localparam int YW  = 6;

    localparam logic [CHW-1:0] CH_BS       = 8'h08;
    localparam logic [CHW-1:0] CH_TAB      = 8'h09;
    localparam logic [CHW-1:0] CH_LF       = 8'h0A;
    localparam logic [CHW-1:0] CH_CR       = 8'h0D;
    localparam logic [CHW-1:0] CH_SPACE    = 8'h20;
    localparam logic [CHW-1:0] CH_PRINT_HI = 8'h7E;
    localparam logic [ATW-1:0] ATTR_RESET  = 8'h07;

    typedef enum logic [OPW-1:0] {
        OP_PUT,
        OP_MARK,
        OP_CLEAR,
        OP_READ
    } t_opcode;

    typedef enum logic {
        CFG_TEXT_ATTRIBUTE,
        CFG_OUTPUT_ENABLE
    } t_cfg_index;

    typedef enum logic [2:0] {
        K_PRINT,
        K_NEWLINE,
        K_TAB,
        K_BACKSPACE,
        K_IGNORE,
        K_MARK,
        K_CLEAR,
        K_READ
    } t_kind;

    typedef struct packed {
        t_kind          kind;
        logic [CHW-1:0] ch;
        logic [RW-1:0]  row;
        logic [CW-1:0]  col;
        logic           in_range;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    typedef struct packed {
        logic init_busy;
        logic pop;
    } t_back_stat;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EMIT,
        S_SCROLL,
        S_CLEAR,
        S_READ,
        S_DONE
    } t_state;

endpackage

/* hdl/tccw_if.sv */
// handshake channels: operation input, result output, register writes
interface tccw_in_if;
    logic                      valid;
    logic                      ready;
    logic [tccw_pkg::OPW-1:0]  opcode;
    logic [tccw_pkg::CHW-1:0]  char_code;
    logic [tccw_pkg::RW-1:0]   cell_row;
    logic [tccw_pkg::CW-1:0]   cell_column;
    modport source (output valid, opcode, char_code, cell_row, cell_column, input ready);
    modport sink   (input valid, opcode, char_code, cell_row, cell_column, output ready);
endinterface

interface tccw_out_if;
    logic                      valid;
    logic                      ready;
    logic [tccw_pkg::XW-1:0]   cursor_column;
    logic [tccw_pkg::RW-1:0]   cursor_row;
    logic [tccw_pkg::CHW-1:0]  read_char;
    logic [tccw_pkg::ATW-1:0]  read_attr;
    modport source (output valid, cursor_column, cursor_row, read_char, read_attr,
                    input ready);
    modport sink   (input valid, cursor_column, cursor_row, read_char, read_attr,
                    output ready);
endinterface

interface tccw_cfg_if;
    logic                      valid;
    logic                      ready;
    logic                      index;
    logic [tccw_pkg::ATW-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/tccw_front.sv */
// front end: accepts operation beats, classifies them, holds them in a short queue
module tccw_front #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    tccw_in_if.sink              i_in,
    input  tccw_pkg::t_back_stat i_stat,
    output tccw_pkg::t_q_head    o_head
);
    import tccw_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push;

    always_comb begin
        w_cmd.ch       = i_in.char_code;
        w_cmd.row      = i_in.cell_row;
        w_cmd.col      = i_in.cell_column;
        w_cmd.in_range = (32'(i_in.cell_row) < ROWS) && (32'(i_in.cell_column) < COLUMNS);
        unique case (t_opcode'(i_in.opcode))
            OP_PUT: begin
                priority if (i_in.char_code == CH_BS) begin
                    w_cmd.kind = K_BACKSPACE;
                end else if (i_in.char_code == CH_LF || i_in.char_code == CH_CR) begin
                    w_cmd.kind = K_NEWLINE;
                end else if (i_in.char_code == CH_TAB) begin
                    w_cmd.kind = K_TAB;
                end else if (i_in.char_code >= CH_SPACE && i_in.char_code <= CH_PRINT_HI) begin
                    w_cmd.kind = K_PRINT;
                end else begin
                    w_cmd.kind = K_IGNORE;
                end
            end
            OP_MARK:  w_cmd.kind = K_MARK;
            OP_CLEAR: w_cmd.kind = K_CLEAR;
            OP_READ:  w_cmd.kind = K_READ;
            default:  w_cmd.kind = K_IGNORE;
        endcase
    end

    assign i_in.ready   = (r_cnt != 2'd2) && !i_stat.init_busy;
    assign w_push       = i_in.valid && i_in.ready;
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.cmd   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (i_stat.pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_stat.pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
    end

endmodule

/* hdl/tccw_back.sv */
// back end: screen store, cursor, scroll and clear sweeps, result register
module tccw_back #(
    parameter int COLUMNS   = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS      = tccw_pkg::ROWS_DEF,
    parameter int TAB_WIDTH = tccw_pkg::TAB_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tccw_pkg::t_q_head    i_head,
    output tccw_pkg::t_back_stat o_stat,
    tccw_cfg_if.sink             i_cfg,
    tccw_out_if.source           o_out
);
    import tccw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int IW    = $clog2(CELLS + 1);
    localparam int TW    = $clog2(TAB_WIDTH + 1);

    logic [15:0]    r_mem [CELLS];
    logic [15:0]    r_rdata;

    t_state         r_state,      n_state;
    t_state         r_after,      n_after;
    logic [XW-1:0]  r_x,          n_x;
    logic [YW-1:0]  r_y,          n_y;
    logic [XW-1:0]  r_lim,        n_lim;
    logic [ATW-1:0] r_attr,       n_attr;
    logic           r_en,         n_en;
    logic [ATW-1:0] r_sweep_attr, n_sweep_attr;
    logic [IW-1:0]  r_idx,        n_idx;
    logic           r_pend,       n_pend;
    logic           r_pend_blank, n_pend_blank;
    logic [AW-1:0]  r_pend_addr,  n_pend_addr;
    logic [TW-1:0]  r_left,       n_left;
    logic [CHW-1:0] r_ch,         n_ch;
    logic [CHW-1:0] r_rch,        n_rch;
    logic [ATW-1:0] r_rattr,      n_rattr;
    logic           r_out_valid,  n_out_valid;
    logic [XW-1:0]  r_out_x,      n_out_x;
    logic [RW-1:0]  r_out_y,      n_out_y;
    logic [CHW-1:0] r_out_rch,    n_out_rch;
    logic [ATW-1:0] r_out_rattr,  n_out_rattr;

    logic           w_we;
    logic [AW-1:0]  w_wa;
    logic [15:0]    w_wd;
    logic [AW-1:0]  w_ra;
    logic           w_pop;

    function automatic logic [AW-1:0] f_addr(input logic [YW-1:0] y, input logic [XW-1:0] x);
        return AW'(y) * AW'(COLUMNS) + AW'(x);
    endfunction

    assign o_stat.init_busy    = (r_state == S_INIT);
    assign o_stat.pop          = w_pop;
    assign i_cfg.ready         = 1'b1;
    assign o_out.valid         = r_out_valid;
    assign o_out.cursor_column = r_out_x;
    assign o_out.cursor_row    = r_out_y;
    assign o_out.read_char     = r_out_rch;
    assign o_out.read_attr     = r_out_rattr;

    always_comb begin
        n_state      = r_state;
        n_after      = r_after;
        n_x          = r_x;
        n_y          = r_y;
        n_lim        = r_lim;
        n_attr       = r_attr;
        n_en         = r_en;
        n_sweep_attr = r_sweep_attr;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_pend_blank = r_pend_blank;
        n_pend_addr  = r_pend_addr;
        n_left       = r_left;
        n_ch         = r_ch;
        n_rch        = r_rch;
        n_rattr      = r_rattr;
        n_out_valid  = r_out_valid;
        n_out_x      = r_out_x;
        n_out_y      = r_out_y;
        n_out_rch    = r_out_rch;
        n_out_rattr  = r_out_rattr;
        w_we         = 1'b0;
        w_wa         = '0;
        w_wd         = '0;
        w_ra         = '0;
        w_pop        = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg.valid) begin
            unique case (t_cfg_index'(i_cfg.index))
                CFG_TEXT_ATTRIBUTE: n_attr = i_cfg.data;
                CFG_OUTPUT_ENABLE:  n_en   = i_cfg.data[0];
                default:            n_en   = r_en;
            endcase
        end

        unique case (r_state)
            S_INIT, S_CLEAR: begin
                w_we = 1'b1;
                w_wa = AW'(r_idx);
                w_wd = {r_sweep_attr, CH_SPACE};
                if (r_idx == IW'(CELLS - 1)) begin
                    n_state = (r_state == S_INIT) ? S_IDLE : S_DONE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_IDLE: begin
                if (i_head.valid && !r_out_valid) begin
                    w_pop   = 1'b1;
                    n_rch   = '0;
                    n_rattr = '0;
                    n_state = S_DONE;
                    unique case (i_head.cmd.kind)
                        K_PRINT: begin
                            if (r_en) begin
                                n_ch    = i_head.cmd.ch;
                                n_left  = TW'(1);
                                n_state = S_EMIT;
                            end
                        end
                        K_TAB: begin
                            if (r_en) begin
                                n_ch    = CH_SPACE;
                                n_left  = TW'(TAB_WIDTH);
                                n_state = S_EMIT;
                            end
                        end
                        K_NEWLINE: begin
                            if (r_en) begin
                                n_x = '0;
                                if (r_y == YW'(ROWS - 1)) begin
                                    n_after = S_DONE;
                                    n_idx   = '0;
                                    n_pend  = 1'b0;
                                    n_state = S_SCROLL;
                                end else begin
                                    n_y = r_y + YW'(1);
                                end
                            end
                        end
                        K_BACKSPACE: begin
                            if (r_en && r_x != r_lim) begin
                                if (r_x == '0) begin
                                    if (r_y != '0) begin
                                        n_y  = r_y - YW'(1);
                                        n_x  = XW'(COLUMNS - 1);
                                        w_we = 1'b1;
                                    end
                                end else begin
                                    n_x  = r_x - XW'(1);
                                    w_we = 1'b1;
                                end
                                w_wa = f_addr(n_y, n_x);
                                w_wd = {r_attr, CH_SPACE};
                            end
                        end
                        K_MARK: n_lim = r_x;
                        K_CLEAR: begin
                            n_x          = '0;
                            n_y          = '0;
                            n_lim        = '0;
                            n_sweep_attr = r_attr;
                            n_idx        = '0;
                            n_state      = S_CLEAR;
                        end
                        K_READ: begin
                            if (i_head.cmd.in_range) begin
                                w_ra    = f_addr(YW'(i_head.cmd.row), XW'(i_head.cmd.col));
                                n_state = S_READ;
                            end
                        end
                        K_IGNORE: n_state = S_DONE;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_EMIT: begin
                w_we   = 1'b1;
                w_wa   = f_addr(r_y, r_x);
                w_wd   = {r_attr, r_ch};
                n_left = r_left - TW'(1);
                n_state = (r_left == TW'(1)) ? S_DONE : S_EMIT;
                if (r_x == XW'(COLUMNS - 1)) begin
                    n_x = '0;
                    if (r_y == YW'(ROWS - 1)) begin
                        n_after = n_state;
                        n_idx   = '0;
                        n_pend  = 1'b0;
                        n_state = S_SCROLL;
                    end else begin
                        n_y = r_y + YW'(1);
                    end
                end else begin
                    n_x = r_x + XW'(1);
                end
            end
            S_SCROLL: begin
                // second stage writes the cell that the first stage fetched in the previous cycle
                if (r_pend) begin
                    w_we = 1'b1;
                    w_wa = r_pend_addr;
                    w_wd = {r_attr, r_pend_blank ? CH_SPACE : r_rdata[CHW-1:0]};
                end
                // first stage fetches the cell one row below, or marks a blank for the last row
                if (r_idx < IW'(CELLS)) begin
                    n_pend      = 1'b1;
                    n_pend_addr = AW'(r_idx);
                    if (r_idx < IW'(CELLS - COLUMNS)) begin
                        w_ra         = AW'(r_idx + IW'(COLUMNS));
                        n_pend_blank = 1'b0;
                    end else begin
                        n_pend_blank = 1'b1;
                    end
                    n_idx = r_idx + IW'(1);
                end else begin
                    n_pend  = 1'b0;
                    n_state = r_after;
                end
            end
            S_READ: begin
                n_rch   = r_rdata[CHW-1:0];
                n_rattr = r_rdata[15:CHW];
                n_state = S_DONE;
            end
            S_DONE: begin
                n_out_valid = 1'b1;
                n_out_x     = r_x;
                n_out_y     = RW'(r_y);
                n_out_rch   = r_rch;
                n_out_rattr = r_rattr;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_x          <= '0;
            r_y          <= '0;
            r_lim        <= '0;
            r_attr       <= ATTR_RESET;
            r_en         <= 1'b1;
            r_sweep_attr <= ATTR_RESET;
            r_idx        <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_x          <= n_x;
            r_y          <= n_y;
            r_lim        <= n_lim;
            r_attr       <= n_attr;
            r_en         <= n_en;
            r_sweep_attr <= n_sweep_attr;
            r_idx        <= n_idx;
            r_pend       <= n_pend;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_after      <= n_after;
        r_pend_blank <= n_pend_blank;
        r_pend_addr  <= n_pend_addr;
        r_left       <= n_left;
        r_ch         <= n_ch;
        r_rch        <= n_rch;
        r_rattr      <= n_rattr;
        r_out_x      <= n_out_x;
        r_out_y      <= n_out_y;
        r_out_rch    <= n_out_rch;
        r_out_rattr  <= n_out_rattr;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rdata <= r_mem[w_ra];
    end

endmodule

/* hdl/text_console_char_writer_top.sv */
// top level of the text console character writer
//
//  channel   dir  handshake           carries
//  i_in      in   valid / ready       opcode, char_code, cell_row, cell_column
//  o_out     out  valid / ready       cursor_column, cursor_row, read_char, read_attr
//  i_cfg     in   valid / ready(=1)   index, data (text attribute, output enable)
//
//  one operation at a time in the back end
//  a scroll moves one cell a cycle through the store
//  after reset a sweep blanks the store, i_in.ready stays low
//  the queue keeps taking beats, up to its two entries, while a result waits on o_out
module text_console_char_writer_top #(
    parameter int COLUMNS   = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS      = tccw_pkg::ROWS_DEF,
    parameter int TAB_WIDTH = tccw_pkg::TAB_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tccw_in_if.sink    i_in,
    tccw_cfg_if.sink   i_cfg,
    tccw_out_if.source o_out
);
    import tccw_pkg::*;

    // queue head toward the back end, status and pop back to the front
    t_q_head    w_head;
    t_back_stat w_stat;

    tccw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_stat  (w_stat),
        .o_head  (w_head)
    );

    // executes operations against the screen store
    tccw_back #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_stat  (w_stat),
        .i_cfg   (i_cfg),
        .o_out   (o_out)
    );

endmodule

/* hdl/tccw_checker.sv */
// port checker for the text console character writer, bound to the top level
module tccw_checker #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_ready,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic [tccw_pkg::XW-1:0]  i_col,
    input logic [tccw_pkg::RW-1:0]  i_row
);
    import tccw_pkg::*;

    // result beat held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_col) && $stable(i_row))
        else $error("result beat dropped or changed under stall");

    // cursor stays on screen
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> 32'(i_col) < COLUMNS)
        else $error("cursor column off screen");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> 32'(i_row) < ROWS)
        else $error("cursor row off screen");

    // store sweep after reset holds off input
    a_init_block: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input taken during reset sweep");

endmodule

bind text_console_char_writer_top tccw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_col       (o_out.cursor_column),
    .i_row       (o_out.cursor_row)
);

/* tb/tccw_test_if.sv */
// testbench constants derived from the block's package
package tccw_test_consts;
    localparam int SCREEN_CELLS = tccw_pkg::COLUMNS_DEF * tccw_pkg::ROWS_DEF;
endpackage

/* tb/text_console_char_writer_top_test.sv */
// testbench of the text console character writer: directed and random operations
module text_console_char_writer_top_test;
    import tccw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCOL = COLUMNS_DEF;
    localparam int NROW = ROWS_DEF;
    localparam int NTAB = TAB_WIDTH_DEF;
    localparam int NCELL = tccw_test_consts::SCREEN_CELLS;

    typedef struct packed {
        logic [XW-1:0]  col;
        logic [RW-1:0]  row;
        logic [CHW-1:0] ch;
        logic [ATW-1:0] attr;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tccw_in_if  in_ch();
    tccw_out_if out_ch();
    tccw_cfg_if cfg_ch();

    text_console_char_writer_top u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .i_cfg  (cfg_ch),
        .o_out  (out_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predicted console state
    logic [15:0] screen_q [NCELL];
    int          cur_x, cur_y, bs_limit;
    logic [7:0]  attr_q;
    logic        enable_q;

    t_result expected_results[$];
    int      fail_count = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      hold_cycles = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        fail_count++;
    endtask

    function automatic void write_cell(int r, int c, logic [7:0] ch);
        if (r < NROW && c < NCOL) screen_q[r*NCOL + c] = {attr_q, ch};
    endfunction

    function automatic void shift_rows_up();
        if (cur_y < NROW) return;
        for (int i = 0; i < (NROW-1)*NCOL; i++) screen_q[i] = {attr_q, screen_q[i+NCOL][7:0]};
        for (int i = (NROW-1)*NCOL; i < NCELL; i++) screen_q[i] = {attr_q, CH_SPACE};
        cur_y = NROW - 1;
    endfunction

    function automatic void emit_char(logic [7:0] ch);
        write_cell(cur_y, cur_x, ch);
        cur_x++;
        if (cur_x >= NCOL) begin
            cur_x = 0;
            cur_y++;
        end
        shift_rows_up();
    endfunction

    function automatic void blank_screen();
        for (int i = 0; i < NCELL; i++) screen_q[i] = {attr_q, CH_SPACE};
        cur_x = 0;
        cur_y = 0;
        bs_limit = 0;
    endfunction

    function automatic void put_char(logic [7:0] c);
        if (!enable_q) return;
        if (c == CH_BS) begin
            if (cur_x == bs_limit) return;
            if (cur_x == 0) begin
                if (cur_y == 0) return;
                cur_y--;
                cur_x = NCOL - 1;
            end else begin
                cur_x--;
            end
            write_cell(cur_y, cur_x, CH_SPACE);
        end else if (c == CH_LF || c == CH_CR) begin
            cur_y++;
            cur_x = 0;
            shift_rows_up();
        end else if (c == CH_TAB) begin
            for (int i = 0; i < NTAB; i++) emit_char(CH_SPACE);
        end else if (c >= CH_SPACE && c <= CH_PRINT_HI) begin
            emit_char(c);
        end
    endfunction

    // works out the result of one operation and advances the console state
    function automatic t_result predict_console(t_opcode op, logic [7:0] ch,
                                                logic [4:0] r, logic [6:0] c);
        t_result res;
        res = '0;
        case (op)
            OP_PUT: put_char(ch);
            OP_MARK: bs_limit = cur_x;
            OP_CLEAR: blank_screen();
            OP_READ: begin
                if (r < NROW && c < NCOL) begin
                    res.ch   = screen_q[r*NCOL + c][7:0];
                    res.attr = screen_q[r*NCOL + c][15:8];
                end
            end
        endcase
        res.col = cur_x[XW-1:0];
        res.row = cur_y[RW-1:0];
        return res;
    endfunction

    // one beat on the operation channel, random gaps before it
    task automatic send_op(t_opcode op, logic [7:0] ch, logic [4:0] r, logic [6:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= op;
        in_ch.char_code   <= ch;
        in_ch.cell_row    <= r;
        in_ch.cell_column <= c;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        expected_results.push_back(predict_console(op, ch, r, c));
    endtask

    task automatic put(logic [7:0] ch);
        send_op(OP_PUT, ch, $urandom_range(31), $urandom_range(127));
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (NCELL + 20) @(posedge i_clk);
    endtask

    // register write, only while idle
    task automatic write_reg(t_cfg_index idx, logic [7:0] data);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_TEXT_ATTRIBUTE) attr_q = data;
        else enable_q = data[0];
    endtask

    // receiver: random stall or long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                $display("unexpected result beat");
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (out_ch.cursor_column !== want.col)
                    report_mismatch("cursor_column", out_ch.cursor_column, want.col);
                if (out_ch.cursor_row !== want.row)
                    report_mismatch("cursor_row", out_ch.cursor_row, want.row);
                if (out_ch.read_char !== want.ch)
                    report_mismatch("read_char", out_ch.read_char, want.ch);
                if (out_ch.read_attr !== want.attr)
                    report_mismatch("read_attr", out_ch.read_attr, want.attr);
            end
        end
    end

    function automatic logic [7:0] rand_char();
        int k;
        k = $urandom_range(99);
        if (k < 60) return 8'($urandom_range(8'h20, 8'h7E));
        if (k < 70) return CH_LF;
        if (k < 74) return CH_CR;
        if (k < 80) return CH_TAB;
        if (k < 92) return CH_BS;
        return 8'($urandom_range(255));
    endfunction

    task automatic test_directed();
        send_op(OP_READ, 8'hFF, 5'd0, 7'd0);
        send_op(OP_READ, 8'h00, 5'd24, 7'd79);
        send_op(OP_READ, 8'h00, 5'd25, 7'd0);
        send_op(OP_READ, 8'h00, 5'd31, 7'd127);
        put(CH_BS);                    // top-left corner stop
        put(8'h20);
        put(8'h7E);
        put(8'h7F);                    // ignored
        put(8'h00);
        put(8'hFF);
        put(CH_TAB);
        send_op(OP_MARK, 8'h00, 5'd0, 7'd0);
        put(8'h41);
        put(CH_BS);
        put(CH_BS);                    // stops at limit
        put(CH_CR);
        put(CH_BS);                    // wraps back to row above
        send_op(OP_READ, 8'h00, 5'd0, 7'd79);
        put(CH_LF);
        send_op(OP_CLEAR, 8'h00, 5'd31, 7'd127);
        send_op(OP_READ, 8'h00, 5'd0, 7'd5);
    endtask

    task automatic test_wrap_and_scroll();
        for (int i = 0; i < NROW + 2; i++) put(CH_LF);
        for (int i = 0; i < 6; i++) put(CH_TAB);
        for (int i = 0; i < 60; i++) put(8'($urandom_range(8'h21, 8'h7E)));
        send_op(OP_READ, 8'h00, 5'(NROW-1), 7'd3);
        send_op(OP_READ, 8'h00, 5'(NROW-2), 7'd79);
    endtask

    task automatic test_random(int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 70) put(rand_char());
            else if (k < 75) send_op(OP_MARK, 8'($urandom), 5'($urandom), 7'($urandom));
            else if (k < 77) send_op(OP_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
            else if (k < 92) send_op(OP_READ, 8'($urandom), 5'($urandom_range(NROW-1)),
                                     7'($urandom_range(NCOL-1)));
            else send_op(OP_READ, 8'($urandom), 5'($urandom), 7'($urandom));
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        send_idle_pct = 0;
        for (int i = 0; i < 30; i++) put(8'($urandom_range(8'h20, 8'h7E)));
        drain();
        for (int i = 0; i < 10; i++) send_op(OP_READ, 8'h00, 5'($urandom_range(4)),
                                             7'($urandom_range(NCOL-1)));
    endtask

    task automatic test_output_disable();
        write_reg(CFG_OUTPUT_ENABLE, 8'h00);
        for (int i = 0; i < 10; i++) put(rand_char());
        put(CH_LF);
        send_op(OP_CLEAR, 8'h00, 5'd0, 7'd0);
        send_op(OP_READ, 8'h00, 5'd0, 7'd0);
        write_reg(CFG_OUTPUT_ENABLE, 8'h01);
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_PUT;
        in_ch.char_code = '0;
        in_ch.cell_row = '0;
        in_ch.cell_column = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_TEXT_ATTRIBUTE;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        attr_q = ATTR_RESET;
        enable_q = 1'b1;
        blank_screen();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_wrap_and_scroll();
        test_backpressure();
        test_output_disable();
        // phases of idling and attribute settings, extremes included
        write_reg(CFG_TEXT_ATTRIBUTE, 8'hFF);
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random(150);
        write_reg(CFG_TEXT_ATTRIBUTE, 8'h00);
        send_idle_pct = 85; recv_stall_pct = 0;  test_random(100);
        write_reg(CFG_TEXT_ATTRIBUTE, 8'($urandom));
        send_idle_pct = 0;  recv_stall_pct = 85; test_random(100);
        write_reg(CFG_TEXT_ATTRIBUTE, 8'($urandom));
        send_idle_pct = 25; recv_stall_pct = 25; test_random(150);
        send_idle_pct = 0;  recv_stall_pct = 0;
        drain();

        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end
endmodule
